### sv/huffman_code_bit_packer_core_macros.svh
// Assertion macros for the Huffman bit packer core.
`ifndef HUFFMAN_CODE_BIT_PACKER_CORE_MACROS_SVH
`define HUFFMAN_CODE_BIT_PACKER_CORE_MACROS_SVH

// Check a condition on the same edge as its trigger.
`define HCBP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a condition with a non-overlapping implication on its trigger.
`define HCBP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/hcbp_pkg.sv
// Types and request codes shared by the Huffman bit packer files.
`timescale 1ns / 1ps
`default_nettype none

package hcbp_pkg;

    localparam int CODE_W = 32;
    localparam int LEN_W  = 6;

    typedef logic [1:0]        req_t;
    typedef logic [7:0]        sym_t;
    typedef logic [CODE_W-1:0] code_t;
    typedef logic [LEN_W-1:0]  len_t;
    typedef logic [7:0]        byte_t;
    typedef logic [2:0]        pad_t;

    localparam req_t REQ_LOAD   = 2'd0;
    localparam req_t REQ_ENCODE = 2'd1;
    localparam req_t REQ_FLUSH  = 2'd2;

endpackage

`default_nettype wire

### sv/hcbp_if.sv
// Request and result channel interfaces of the Huffman bit packer.
`timescale 1ns / 1ps
`default_nettype none

interface hcbp_in_if;
    import hcbp_pkg::*;

    logic  valid;
    logic  ready;
    req_t  req_type;
    sym_t  symbol;
    code_t code_word;
    len_t  code_len;

    modport source (output valid, output req_type, output symbol, output code_word,
                    output code_len, input ready);
    modport sink (input valid, input req_type, input symbol, input code_word,
                  input code_len, output ready);
endinterface

interface hcbp_out_if;
    import hcbp_pkg::*;

    logic  valid;
    logic  ready;
    byte_t out_byte;
    logic  byte_valid;
    pad_t  pad_bits;
    logic  last;

    modport source (output valid, output out_byte, output byte_valid, output pad_bits,
                    output last, input ready);
    modport sink (input valid, input out_byte, input byte_valid, input pad_bits,
                  input last, output ready);
endinterface

`default_nettype wire

### sv/hcbp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module hcbp_ram #(
    parameter int WIDTH = 38,
    parameter int DEPTH = 256,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### sv/huffman_code_bit_packer_core.sv
// Huffman encoder back end: code table RAM, bit accumulator and byte output register.
// A request passes table read stage s1, then the result group register; s1 waits
// while that register is busy. Throughput: one request per cycle while nothing stalls;
// an encode of k bytes (k up to 4) holds the 32-bit result register until all are taken.
// Reset: accumulator, bit count and pipeline valids clear at once; table
// entries are undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none
`include "huffman_code_bit_packer_core_macros.svh"

module huffman_code_bit_packer_core #(
    parameter int MAX_CODE_LEN = 32,
    parameter int SYMBOL_COUNT = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    hcbp_in_if.sink    in_ch,
    hcbp_out_if.source out_ch
);
    import hcbp_pkg::*;

    localparam int LEN_LIMIT = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;
    localparam int ADDR_W    = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
    localparam int ENTRY_W   = CODE_W + LEN_W;

    logic               in_fire;
    logic               out_fire;
    logic               sym_hit;
    logic               is_load;
    logic               is_enc;
    logic               is_flush;
    len_t               ld_len;
    logic               wr_en;
    logic               rd_en;
    logic [ENTRY_W-1:0] rd_data;
    code_t              ent_code;
    len_t               ent_len;

    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic               s1_flush_reg;
    logic               s1_take;
    logic               s1_adv;
    logic               s1_produces;

    logic [6:0]         acc_reg;
    logic [6:0]         acc_next;
    logic [2:0]         cnt_reg;
    logic [2:0]         cnt_next;

    logic [32:0]        mask_wide;
    code_t              code_masked;
    logic [38:0]        combined;
    logic [5:0]         total;
    logic [39:0]        aligned;
    logic [2:0]         enc_n;
    logic [7:0]         keep_mask;
    logic [6:0]         enc_acc;
    pad_t               fl_pad;
    byte_t              fl_byte;
    logic [7:0]         fl_shift;

    logic [2:0]         g_left_reg;
    logic [2:0]         g_left_next;
    logic [31:0]        g_bytes_reg;
    logic [31:0]        g_bytes_next;
    logic               g_bv_reg;
    logic               g_bv_next;
    pad_t               g_pad_reg;
    pad_t               g_pad_next;
    logic               g_free;
    logic               g_load;

    assign in_fire  = in_ch.valid && in_ch.ready;
    assign out_fire = out_ch.valid && out_ch.ready;
    assign sym_hit  = (int'(in_ch.symbol) < SYMBOL_COUNT);
    assign is_load  = (in_ch.req_type == REQ_LOAD);
    assign is_enc   = (in_ch.req_type == REQ_ENCODE);
    assign is_flush = (in_ch.req_type == REQ_FLUSH);
    assign ld_len   = (in_ch.code_len > LEN_W'(LEN_LIMIT)) ? LEN_W'(LEN_LIMIT)
                                                           : in_ch.code_len;

    assign wr_en   = in_fire && is_load && sym_hit;
    assign rd_en   = in_fire && is_enc && sym_hit;
    assign s1_take = in_fire && ((is_enc && sym_hit) || is_flush);

    hcbp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SYMBOL_COUNT)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (in_ch.symbol[ADDR_W-1:0]),
        .wr_data ({ld_len, in_ch.code_word}),
        .rd_en   (rd_en),
        .rd_addr (in_ch.symbol[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    assign ent_code = rd_data[CODE_W-1:0];
    assign ent_len  = rd_data[ENTRY_W-1:CODE_W];

    // Append code bits to pending bits and split off complete bytes.
    assign mask_wide   = (33'd1 << ent_len) - 33'd1;
    assign code_masked = ent_code & mask_wide[31:0];
    assign combined    = ({32'b0, acc_reg} << ent_len) | {7'b0, code_masked};
    assign total       = {3'b0, cnt_reg} + ent_len;
    assign aligned     = {1'b0, combined} << (6'd40 - total);
    assign enc_n       = total[5:3];
    assign keep_mask   = (8'd1 << total[2:0]) - 8'd1;
    assign enc_acc     = combined[6:0] & keep_mask[6:0];

    // Pad the partial byte with zeros.
    assign fl_pad   = 3'(4'd8 - {1'b0, cnt_reg});
    assign fl_shift = {1'b0, acc_reg} << fl_pad;
    assign fl_byte  = (cnt_reg == 3'd0) ? 8'd0 : fl_shift;

    assign s1_produces = s1_flush_reg || (enc_n != 3'd0);
    assign g_free      = (g_left_reg == 3'd0) || ((g_left_reg == 3'd1) && out_fire);
    assign s1_adv      = s1_valid_reg && (!s1_produces || g_free);
    assign g_load      = s1_adv && s1_produces;
    assign in_ch.ready = !s1_valid_reg || s1_adv;

    always_comb
    begin
        priority if (s1_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_comb
    begin
        acc_next = acc_reg;
        cnt_next = cnt_reg;
        if (s1_adv)
        begin
            if (s1_flush_reg)
            begin
                acc_next = 7'd0;
                cnt_next = 3'd0;
            end
            else
            begin
                acc_next = enc_acc;
                cnt_next = total[2:0];
            end
        end
    end

    always_comb
    begin
        g_left_next  = g_left_reg;
        g_bytes_next = g_bytes_reg;
        g_bv_next    = g_bv_reg;
        g_pad_next   = g_pad_reg;
        priority if (g_load && s1_flush_reg)
        begin
            g_left_next  = 3'd1;
            g_bytes_next = {fl_byte, 24'b0};
            g_bv_next    = (cnt_reg != 3'd0);
            g_pad_next   = fl_pad;
        end
        else if (g_load)
        begin
            g_left_next  = enc_n;
            g_bytes_next = aligned[39:8];
            g_bv_next    = 1'b1;
            g_pad_next   = 3'd0;
        end
        else if (out_fire)
        begin
            g_left_next  = g_left_reg - 3'd1;
            g_bytes_next = {g_bytes_reg[23:0], 8'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            acc_reg      <= 7'd0;
            cnt_reg      <= 3'd0;
            g_left_reg   <= 3'd0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            acc_reg      <= acc_next;
            cnt_reg      <= cnt_next;
            g_left_reg   <= g_left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_take)
        begin
            s1_flush_reg <= is_flush;
        end
        g_bytes_reg <= g_bytes_next;
        g_bv_reg    <= g_bv_next;
        g_pad_reg   <= g_pad_next;
    end

    assign out_ch.valid      = (g_left_reg != 3'd0);
    assign out_ch.out_byte   = g_bytes_reg[31:24];
    assign out_ch.byte_valid = g_bv_reg;
    assign out_ch.pad_bits   = g_pad_reg;
    assign out_ch.last       = (g_left_reg == 3'd1);

    `HCBP_ASSERT_SAME(a_acc_clean, 1'b1, ((acc_reg >> cnt_reg) == 7'd0),
        "pending bits above bit count not zero")
    `HCBP_ASSERT_NEXT(a_flush_clears, (s1_adv && s1_flush_reg),
        ((acc_reg == 7'd0) && (cnt_reg == 3'd0)), "flush left pending bits")
    `HCBP_ASSERT_SAME(a_group_bound, 1'b1, (g_left_reg <= 3'd4),
        "more than four result beats pending")

endmodule

`default_nettype wire

### dv/huffman_code_bit_packer_core_tb.sv
// Self-checking testbench for the Huffman bit packer core: table loads, encodes, flushes, unknown requests.
`timescale 1ns / 1ps

module huffman_code_bit_packer_core_tb;
    import hcbp_pkg::*;

    localparam int   MAX_CODE_LEN  = 32;
    localparam int   SYMBOL_COUNT  = 256;
    localparam int   CODE_LIMIT    = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;
    localparam req_t REQ_UNKNOWN   = 2'd3;
    localparam int   RANDOM_ITEMS  = 345;
    localparam int   CALM_TAIL     = 40;
    localparam int   STALL_LIMIT   = 2000;
    localparam int   DRAIN_CYCLES  = 10;

    typedef struct packed {
        req_t  req;
        sym_t  sym;
        code_t code;
        len_t  len;
    } packer_req_t;

    typedef struct packed {
        byte_t out_byte;
        logic  byte_valid;
        pad_t  pad_bits;
        logic  last;
    } byte_beat_t;

    logic clk;
    logic rst_n;

    hcbp_in_if  in_ch ();
    hcbp_out_if out_ch ();

    huffman_code_bit_packer_core #(
        .MAX_CODE_LEN(MAX_CODE_LEN),
        .SYMBOL_COUNT(SYMBOL_COUNT)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .out_ch(out_ch)
    );

    packer_req_t request_q[$];
    byte_beat_t  byte_expect_q[$];
    sym_t        loaded_syms[$];
    bit          sym_loaded[SYMBOL_COUNT];

    code_t       code_tab[SYMBOL_COUNT];
    len_t        len_tab[SYMBOL_COUNT];
    logic [6:0]  pend_bits;
    logic [2:0]  pend_cnt;

    int          req_total;
    int          req_accepted;
    int          mismatches;
    int          idle_pct;
    int          in_gap;
    int          out_gap;
    int          quiet_cycles;
    packer_req_t next_req;
    packer_req_t seen_req;
    byte_beat_t  want;

    always #4 clk = ~clk;

    task automatic add_request(input req_t req, input sym_t sym, input code_t code,
                               input len_t len);
        packer_req_t r;
        r.req  = req;
        r.sym  = sym;
        r.code = code;
        r.len  = len;
        request_q.push_back(r);
        if (req == REQ_LOAD && !sym_loaded[sym])
        begin
            sym_loaded[sym] = 1'b1;
            loaded_syms.push_back(sym);
        end
    endtask

    task automatic push_beat(input byte_t b, input logic v, input pad_t p, input logic l);
        byte_beat_t e;
        e.out_byte   = b;
        e.byte_valid = v;
        e.pad_bits   = p;
        e.last       = l;
        byte_expect_q.push_back(e);
    endtask

    task automatic pack_request(input packer_req_t r);
        logic [38:0] bits;
        logic [38:0] mask;
        int unsigned len;
        int unsigned total;
        int unsigned pad;
        unique case (r.req)
            REQ_LOAD:
            begin
                code_tab[r.sym] = r.code;
                len_tab[r.sym]  = (r.len > CODE_LIMIT) ? len_t'(CODE_LIMIT) : r.len;
            end
            REQ_ENCODE:
            begin
                len   = len_tab[r.sym];
                mask  = (39'd1 << len) - 39'd1;
                bits  = ({32'd0, pend_bits} << len) | ({7'd0, code_tab[r.sym]} & mask);
                total = pend_cnt + len;
                while (total >= 8)
                begin
                    total = total - 8;
                    push_beat(byte_t'(bits >> total), 1'b1, 3'd0, total < 8);
                end
                pend_cnt  = total[2:0];
                pend_bits = 7'(bits & ((39'd1 << total) - 39'd1));
            end
            REQ_FLUSH:
            begin
                if (pend_cnt == 0)
                begin
                    push_beat(8'd0, 1'b0, 3'd0, 1'b1);
                end
                else
                begin
                    pad = 8 - pend_cnt;
                    push_beat(byte_t'({1'b0, pend_bits} << pad), 1'b1, pad_t'(pad), 1'b1);
                end
                pend_bits = '0;
                pend_cnt  = '0;
            end
            default: ;
        endcase
    endtask

    // Request driver: hold each beat until taken, idle in bursts between beats.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!in_ch.valid || in_ch.ready)
            begin
                if (in_gap != 0)
                begin
                    in_gap      <= in_gap - 1;
                    in_ch.valid <= 1'b0;
                end
                else if (request_q.size() != 0)
                begin
                    next_req = request_q.pop_front();
                    in_ch.valid     <= 1'b1;
                    in_ch.req_type  <= next_req.req;
                    in_ch.symbol    <= next_req.sym;
                    in_ch.code_word <= next_req.code;
                    in_ch.code_len  <= next_req.len;
                    if ($urandom_range(99) < idle_pct)
                        in_gap <= $urandom_range(10, 1);
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result sink: stall in bursts.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_gap != 0)
            begin
                out_gap      <= out_gap - 1;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                if ($urandom_range(99) < idle_pct)
                    out_gap <= $urandom_range(10, 1);
            end
        end
    end

    // Monitor: predict on request beats, check result beats, watch for a hang.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                seen_req.req  = in_ch.req_type;
                seen_req.sym  = in_ch.symbol;
                seen_req.code = in_ch.code_word;
                seen_req.len  = in_ch.code_len;
                pack_request(seen_req);
                req_accepted++;
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (byte_expect_q.size() == 0)
                begin
                    $error("result beat with nothing expected: out_byte %0h", out_ch.out_byte);
                    mismatches++;
                end
                else
                begin
                    want = byte_expect_q.pop_front();
                    if (out_ch.out_byte !== want.out_byte)
                    begin
                        $error("out_byte expected %0h actual %0h", want.out_byte,
                               out_ch.out_byte);
                        mismatches++;
                    end
                    if (out_ch.byte_valid !== want.byte_valid)
                    begin
                        $error("byte_valid expected %0b actual %0b", want.byte_valid,
                               out_ch.byte_valid);
                        mismatches++;
                    end
                    if (out_ch.pad_bits !== want.pad_bits)
                    begin
                        $error("pad_bits expected %0d actual %0d", want.pad_bits,
                               out_ch.pad_bits);
                        mismatches++;
                    end
                    if (out_ch.last !== want.last)
                    begin
                        $error("last expected %0b actual %0b", want.last, out_ch.last);
                        mismatches++;
                    end
                end
            end
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles + 1 >= STALL_LIMIT)
            begin
                $display("huffman_code_bit_packer_core_tb NOT OK");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial
    begin
        int counted;
        int pick;
        int cyc;
        int len_sel;
        int unsigned len;

        clk             = 1'b0;
        rst_n           = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.req_type  = REQ_LOAD;
        in_ch.symbol    = '0;
        in_ch.code_word = '0;
        in_ch.code_len  = '0;
        out_ch.ready    = 1'b0;
        in_gap          = 0;
        out_gap         = 0;
        quiet_cycles    = 0;
        req_accepted    = 0;
        mismatches      = 0;
        idle_pct        = 30;
        pend_bits       = '0;
        pend_cnt        = '0;
        foreach (sym_loaded[i])
            sym_loaded[i] = 1'b0;

        // Directed: empty flush, unknown request, length extremes, full byte then flush.
        add_request(REQ_FLUSH,   8'h00, 32'h0,         6'd0);
        add_request(REQ_UNKNOWN, 8'hAA, 32'hFFFF_FFFF, 6'd63);
        add_request(REQ_LOAD,    8'h00, 32'hFFFF_FFFF, 6'd32);
        add_request(REQ_LOAD,    8'hFF, 32'h0000_0000, 6'd0);
        add_request(REQ_LOAD,    8'h80, 32'hAAAA_AAAA, 6'd63);
        add_request(REQ_LOAD,    8'h01, 32'hFFFF_FFFE, 6'd1);
        add_request(REQ_LOAD,    8'h7F, 32'h0000_0005, 6'd3);
        add_request(REQ_LOAD,    8'h55, 32'h1234_5678, 6'd33);
        add_request(REQ_LOAD,    8'h10, 32'h0000_00C3, 6'd8);
        add_request(REQ_ENCODE,  8'hFF, 32'h0,         6'd0);
        add_request(REQ_ENCODE,  8'h00, 32'h0,         6'd0);
        add_request(REQ_ENCODE,  8'h7F, 32'h0,         6'd0);
        add_request(REQ_ENCODE,  8'h80, 32'h0,         6'd0);
        add_request(REQ_FLUSH,   8'hFF, 32'hFFFF_FFFF, 6'd63);
        add_request(REQ_ENCODE,  8'h01, 32'h0,         6'd0);
        add_request(REQ_FLUSH,   8'h00, 32'h0,         6'd0);
        add_request(REQ_ENCODE,  8'h7F, 32'h0,         6'd0);
        add_request(REQ_ENCODE,  8'h7F, 32'h0,         6'd0);
        add_request(REQ_ENCODE,  8'h01, 32'h0,         6'd0);
        add_request(REQ_ENCODE,  8'h55, 32'h0,         6'd0);
        add_request(REQ_FLUSH,   8'h00, 32'h0,         6'd0);
        add_request(REQ_ENCODE,  8'h10, 32'h0,         6'd0);
        add_request(REQ_FLUSH,   8'h00, 32'h0,         6'd0);
        add_request(REQ_LOAD,    8'h10, 32'h0000_0001, 6'd2);
        add_request(REQ_ENCODE,  8'h10, 32'h0,         6'd0);

        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            pick = $urandom_range(99);
            if (loaded_syms.size() == 0 || pick < 22)
            begin
                len_sel = $urandom_range(99);
                if (len_sel < 5)
                    len = 0;
                else if (len_sel < 70)
                    len = $urandom_range(12, 1);
                else if (len_sel < 90)
                    len = $urandom_range(32, 13);
                else
                    len = $urandom_range(63, 33);
                add_request(REQ_LOAD, sym_t'($urandom_range(255)), code_t'($urandom),
                            len_t'(len));
                counted++;
            end
            else if (pick < 88)
            begin
                add_request(REQ_ENCODE,
                            loaded_syms[$urandom_range(loaded_syms.size() - 1)],
                            code_t'($urandom), len_t'($urandom_range(63)));
                counted++;
            end
            else if (pick < 97)
            begin
                add_request(REQ_FLUSH, sym_t'($urandom_range(255)), code_t'($urandom),
                            len_t'($urandom_range(63)));
                counted++;
            end
            else
            begin
                add_request(REQ_UNKNOWN, sym_t'($urandom_range(255)), code_t'($urandom),
                            len_t'($urandom_range(63)));
            end
        end
        add_request(REQ_FLUSH, 8'h00, 32'h0, 6'd0);
        req_total = request_q.size();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Vary the idle rate over time; drop it near the end.
        cyc = 0;
        while (req_accepted < req_total)
        begin
            @(negedge clk);
            cyc++;
            if (cyc % 150 == 0)
            begin
                case ($urandom_range(2))
                    0:       idle_pct = 0;
                    1:       idle_pct = 20;
                    default: idle_pct = 50;
                endcase
            end
            if (request_q.size() < CALM_TAIL)
                idle_pct = 0;
        end
        while (byte_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("huffman_code_bit_packer_core_tb OK");
        else
            $display("huffman_code_bit_packer_core_tb NOT OK");
        $finish;
    end

endmodule
